// File: hw/rtl/wtm_pkg.sv
package wtm_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int QUO_W    = 32;

    // Default window lengths
    localparam int SHORT_WINDOW_DEF = 5;
    localparam int LONG_WINDOW_DEF  = 12;

    // Windows of at least this length drop their smallest and largest value
    localparam int TRIM_FROM = 5;

    // Item mode codes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } wtm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic do_write;
        logic rd_issue;
        logic div_start;
        logic load_out;
    } wtm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic div_done;
        logic out_free;
    } wtm_status_t;

    // Divisor of a window: trimmed windows lose two samples
    function automatic int trim_divisor(int win);
        return (win >= TRIM_FROM) ? win - 2 : win;
    endfunction

endpackage

// File: hw/rtl/wtm_ram.sv
module wtm_ram
    import wtm_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = LONG_WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/wtm_div.sv
module wtm_div
    import wtm_pkg::*;
#(
    parameter int NUM_W   = SAMPLE_W + 4,
    parameter int DIVISOR = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    output logic [QUO_W-1:0] quo,
    output logic             done
);

    // Reciprocal scaled by 2^SHIFT, rounded up: exact for any NUM_W-bit numerator
    localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int PART_W = 16;
    localparam int PARTS  = (NUM_W + 2 + PART_W - 1) / PART_W;
    localparam int PAD_W  = PARTS * PART_W;
    localparam int PROD_W = NUM_W + PAD_W;
    localparam int IDX_W  = $clog2(PARTS);
    localparam logic [PAD_W-1:0] RECIP_PAD = PAD_W'(RECIP);
    localparam logic [IDX_W-1:0] IDX_TOP   = IDX_W'(PARTS - 1);

    logic [NUM_W-1:0]        num_reg, num_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    busy_reg, busy_next;
    logic [PART_W-1:0]       part;
    logic [NUM_W+PART_W-1:0] partial;

    // Multiply by the reciprocal one 16-bit slice per cycle, top slice first;
    // the quotient is the product shifted down by SHIFT
    always_comb
    begin
        part      = RECIP_PAD[PART_W*idx_reg +: PART_W];
        partial   = num_reg * part;
        num_next  = num_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = num;
            acc_next  = '0;
            idx_next  = IDX_TOP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << PART_W) + PROD_W'(partial);
            idx_next = idx_reg - 1'b1;
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        acc_reg <= acc_next;
    end

    assign quo  = acc_reg[SHIFT +: QUO_W];
    assign done = !busy_reg;

endmodule

// File: hw/rtl/wtm_ctrl.sv
module wtm_ctrl
    import wtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wtm_status_t status,
    output wtm_cmd_t    cmd
);

    wtm_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:    state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = status.out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_WRITE:    cmd.do_write  = 1'b1;
            ST_SCAN:     cmd.rd_issue  = 1'b1;
            ST_DRAIN:    cmd           = '0;
            ST_DIV_LOAD: cmd.div_start = 1'b1;
            ST_DIV:      cmd.load_out  = status.div_done && status.out_free;
            ST_DONE:     cmd.load_out  = status.out_free;
            default:     cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/wtm_datapath.sv
module wtm_datapath
    import wtm_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wtm_cmd_t            cmd,
    output wtm_status_t         status,
    input  logic                mode,
    input  logic [SAMPLE_W-1:0] sample_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] short_mean,
    output logic                short_valid,
    output logic [SAMPLE_W-1:0] long_mean,
    output logic                long_valid
);

    localparam int SLOT_W = $clog2(LONG_WINDOW);
    localparam int CNT_W  = $clog2(LONG_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(LONG_WINDOW);
    localparam bit SHORT_FITS = (SHORT_WINDOW <= LONG_WINDOW);
    localparam bit SHORT_TRIM = (SHORT_WINDOW >= TRIM_FROM);
    localparam bit LONG_TRIM  = (LONG_WINDOW >= TRIM_FROM);
    localparam int SHORT_DIV  = trim_divisor(SHORT_WINDOW);
    localparam int LONG_DIV   = trim_divisor(LONG_WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LONG_WINDOW - 1);
    localparam logic [SLOT_W-1:0] SHORT_IDX = SHORT_FITS ? SLOT_W'(SHORT_WINDOW - 1) : '0;
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(LONG_WINDOW);

    // Captured item
    logic                mode_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Ring bookkeeping and scan pointers
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              acc_en_reg;
    logic [SLOT_W-1:0] acc_idx_reg;
    logic [SAMPLE_W-1:0] rdata;
    logic              ring_we;

    // Accumulators
    logic [SUM_W-1:0]    sum_reg, s_sum_reg, sum_acc;
    logic [SAMPLE_W-1:0] min_reg, max_reg, s_min_reg, s_max_reg, min_acc, max_acc;
    logic                first;

    // Division
    logic [SUM_W-1:0] short_num, long_num;
    logic [QUO_W-1:0] short_quo, long_quo;
    logic             short_done, long_done;
    logic             short_ok, long_ok;

    // Output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] short_mean_reg, long_mean_reg;
    logic                short_valid_reg, long_valid_reg;

    assign ring_we = cmd.do_write && (mode_reg == MODE_ADD);

    wtm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (write_slot_reg),
        .wdata (sample_reg),
        .raddr (rd_slot_reg),
        .rdata (rdata)
    );

    // Slot, count and scan pointer updates
    always_comb
    begin
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        rd_slot_next    = rd_slot_reg;
        idx_next        = idx_reg;
        if (cmd.do_write)
        begin
            idx_next = '0;
            if (mode_reg == MODE_CLEAR)
            begin
                write_slot_next = '0;
                count_next      = '0;
                rd_slot_next    = LAST_SLOT;
            end
            else
            begin
                write_slot_next = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
                count_next      = (count_reg == FULL_CNT) ? count_reg : count_reg + 1'b1;
                rd_slot_next    = write_slot_reg;
            end
        end
        else if (cmd.rd_issue)
        begin
            rd_slot_next = (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - 1'b1;
            idx_next     = idx_reg + 1'b1;
        end
    end

    assign status.scan_last = (idx_reg == LAST_SLOT);

    // Running sum, min and max over the newest-first scan
    always_comb
    begin
        first   = (acc_idx_reg == '0);
        sum_acc = first ? SUM_W'(rdata) : sum_reg + SUM_W'(rdata);
        min_acc = (first || rdata < min_reg) ? rdata : min_reg;
        max_acc = (first || rdata > max_reg) ? rdata : max_reg;
    end

    // Trimmed numerators
    assign short_num = SHORT_TRIM ? s_sum_reg - SUM_W'(s_min_reg) - SUM_W'(s_max_reg)
                                  : s_sum_reg;
    assign long_num  = LONG_TRIM ? sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg) : sum_reg;

    wtm_div #(
        .NUM_W   (SUM_W),
        .DIVISOR (SHORT_DIV)
    ) u_short_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (short_num),
        .quo   (short_quo),
        .done  (short_done)
    );

    wtm_div #(
        .NUM_W   (SUM_W),
        .DIVISOR (LONG_DIV)
    ) u_long_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (long_num),
        .quo   (long_quo),
        .done  (long_done)
    );

    assign status.div_done = short_done && long_done;

    // Validity from the count after this item
    assign short_ok = SHORT_FITS && (int'(count_reg) >= SHORT_WINDOW);
    assign long_ok  = (count_reg == FULL_CNT);

    assign status.out_free = !out_valid_reg || out_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            count_reg      <= '0;
            acc_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            acc_en_reg     <= cmd.rd_issue;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        idx_reg     <= idx_next;
        acc_idx_reg <= idx_reg;
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            sample_reg <= sample_ms;
        end
        if (acc_en_reg)
        begin
            sum_reg <= sum_acc;
            min_reg <= min_acc;
            max_reg <= max_acc;
            if (SHORT_FITS && acc_idx_reg == SHORT_IDX)
            begin
                s_sum_reg <= sum_acc;
                s_min_reg <= min_acc;
                s_max_reg <= max_acc;
            end
        end
        if (cmd.load_out)
        begin
            short_valid_reg <= short_ok;
            long_valid_reg  <= long_ok;
            short_mean_reg  <= short_ok ? short_quo : '0;
            long_mean_reg   <= long_ok ? long_quo : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign short_mean  = short_mean_reg;
    assign short_valid = short_valid_reg;
    assign long_mean   = long_mean_reg;
    assign long_valid  = long_valid_reg;

endmodule

// File: hw/rtl/windowed_trimmed_mean_core.sv
// Trimmed mean over a short and a long sliding window of duration samples.
// Input channel (in_valid/in_ready): mode selects add (sample_ms enters the
// ring) or clear (session emptied, sample_ms ignored). Every input transaction
// yields exactly one output transaction (out_valid/out_ready) carrying both
// means, each 0 with its valid flag low until the ring holds a full window.
// Per item: a write step, a scan of the ring RAM through one compare-add unit
// (registered read), a drain step and a divider load step, then the constant
// dividers, one per window, running side by side: three 16-bit slices of a
// reciprocal multiply, after which the result register is loaded. in_ready
// is high only in the idle state between items, so a new item is not taken
// until the previous result has been loaded into the output register.
// The result sits in an output register: a new item is accepted while it
// waits. If the receiver stalls long enough that the next result is ready
// first, the core holds that result and keeps in_ready low until the output
// register frees up.
// Reset empties the session (count and write slot zero) and drops any
// pending result; the ring contents are not cleared and need no pass.
module windowed_trimmed_mean_core
    import wtm_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [SAMPLE_W-1:0] sample_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] short_mean,
    output logic                short_valid,
    output logic [SAMPLE_W-1:0] long_mean,
    output logic                long_valid
);

    wtm_cmd_t    cmd;
    wtm_status_t status;

    wtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wtm_datapath #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .sample_ms   (sample_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .short_mean  (short_mean),
        .short_valid (short_valid),
        .long_mean   (long_mean),
        .long_valid  (long_valid)
    );

endmodule

// File: tb/tb_windowed_trimmed_mean_core.sv
`timescale 1ns / 100ps

// One result transaction: both trimmed means and their valid flags
typedef struct packed {
    logic [31:0] short_mean;
    logic        short_valid;
    logic [31:0] long_mean;
    logic        long_valid;
} mean_pair_t;

// Tracks the sample ring and checks the means of every result transaction
class mean_scoreboard;
    localparam int SHORT_LEN = wtm_pkg::SHORT_WINDOW_DEF;
    localparam int LONG_LEN  = wtm_pkg::LONG_WINDOW_DEF;

    bit [31:0]   ring [LONG_LEN];
    int unsigned filled;
    int unsigned next_slot;
    mean_pair_t  expected_means [$];
    int unsigned mismatches;
    int unsigned samples_seen;
    int unsigned clears_seen;
    int unsigned results_seen;
    int unsigned full_long_seen;

    function new();
        filled         = 0;
        next_slot      = 0;
        mismatches     = 0;
        samples_seen   = 0;
        clears_seen    = 0;
        results_seen   = 0;
        full_long_seen = 0;
    endfunction

    // Trimmed mean over the newest win samples; ok is low if too few are stored
    function bit [31:0] trimmed_mean(int unsigned win, output bit ok);
        bit [63:0]   total;
        bit [31:0]   lo;
        bit [31:0]   hi;
        bit [31:0]   v;
        int unsigned idx;
        int unsigned divisor;
        total = '0;
        lo    = '1;
        hi    = '0;
        ok    = 1'b0;
        if (win == 0 || win > LONG_LEN || filled < win)
            return '0;
        idx = next_slot;
        for (int unsigned i = 0; i < win; i++)
        begin
            idx   = (idx == 0) ? LONG_LEN - 1 : idx - 1;
            v     = ring[idx];
            total = total + v;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        if (win >= wtm_pkg::TRIM_FROM)
        begin
            total   = total - lo - hi;
            divisor = win - 2;
        end
        else
        begin
            divisor = win;
        end
        ok = 1'b1;
        return 32'(total / divisor);
    endfunction

    // Accepted input transaction: update the ring and queue the expected means
    function void note_input(logic m, logic [31:0] s);
        mean_pair_t exp_pair;
        bit         ok;
        if (m == wtm_pkg::MODE_CLEAR)
        begin
            filled    = 0;
            next_slot = 0;
            clears_seen++;
        end
        else
        begin
            ring[next_slot] = s;
            next_slot       = (next_slot + 1 >= LONG_LEN) ? 0 : next_slot + 1;
            if (filled < LONG_LEN) filled++;
            samples_seen++;
        end
        exp_pair.short_mean  = trimmed_mean(SHORT_LEN, ok);
        exp_pair.short_valid = ok;
        exp_pair.long_mean   = trimmed_mean(LONG_LEN, ok);
        exp_pair.long_valid  = ok;
        expected_means = {expected_means, exp_pair};
    endfunction

    // Accepted output transaction: compare against the oldest expectation
    function void check_output(mean_pair_t got);
        mean_pair_t exp_pair;
        results_seen++;
        if (expected_means.size() == 0)
        begin
            $display("%0t: unexpected result short=%0d/%0b long=%0d/%0b", $time,
                     got.short_mean, got.short_valid, got.long_mean, got.long_valid);
            mismatches++;
            return;
        end
        exp_pair = expected_means.pop_front();
        if (exp_pair.long_valid) full_long_seen++;
        if (got.short_mean !== exp_pair.short_mean)
        begin
            $display("%0t: short_mean expected %0d actual %0d", $time,
                     exp_pair.short_mean, got.short_mean);
            mismatches++;
        end
        if (got.short_valid !== exp_pair.short_valid)
        begin
            $display("%0t: short_valid expected %0b actual %0b", $time,
                     exp_pair.short_valid, got.short_valid);
            mismatches++;
        end
        if (got.long_mean !== exp_pair.long_mean)
        begin
            $display("%0t: long_mean expected %0d actual %0d", $time,
                     exp_pair.long_mean, got.long_mean);
            mismatches++;
        end
        if (got.long_valid !== exp_pair.long_valid)
        begin
            $display("%0t: long_valid expected %0b actual %0b", $time,
                     exp_pair.long_valid, got.long_valid);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return expected_means.size();
    endfunction
endclass

module tb_windowed_trimmed_mean_core;
    import wtm_pkg::*;

    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = 120;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                mode        = MODE_ADD;
    logic [SAMPLE_W-1:0] sample_ms   = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [SAMPLE_W-1:0] short_mean;
    logic                short_valid;
    logic [SAMPLE_W-1:0] long_mean;
    logic                long_valid;

    mean_scoreboard board;
    bit             send_calm;
    bit             recv_calm;
    bit [31:0]      last_sample;

    windowed_trimmed_mean_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .sample_ms   (sample_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .short_mean  (short_mean),
        .short_valid (short_valid),
        .long_mean   (long_mean),
        .long_valid  (long_valid)
    );

    always #5 clk = ~clk;

    // Present one input transaction after a random gap and wait for acceptance
    task automatic send_item(logic m, logic [31:0] s);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        sample_ms <= s;
        do @(posedge clk); while (!in_ready);
        board.note_input(m, s);
    endtask

    // Sample value mix: extremes, typical durations, ties and full-range noise
    function automatic bit [31:0] pick_sample();
        bit [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0;
            1:       v = 32'hFFFF_FFFF;
            2, 3, 4: v = $urandom_range(100, 60000);
            5:       v = 32'hFFFF_FFFF - $urandom_range(0, 255);
            6:       v = last_sample;
            default: v = $urandom;
        endcase
        last_sample = v;
        return v;
    endfunction

    // Receiver: random stalls, then take and check one result transaction
    task automatic receive_results();
        int unsigned stall;
        mean_pair_t  got;
        forever
        begin
            if ((board.results_seen % 50) == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            stall = recv_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.short_mean  = short_mean;
            got.short_valid = short_valid;
            got.long_mean   = long_mean;
            got.long_valid  = long_valid;
            board.check_output(got);
        end
    endtask

    // Watchdog: far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb_windowed_trimmed_mean_core: done, errors");
        $finish;
    end

    initial
    begin
        board       = new();
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        last_sample = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            receive_results();
        join_none

        // Directed: clear on empty, all-max window, extremes, full long window, clears
        send_item(MODE_CLEAR, 32'h0);
        repeat (5) send_item(MODE_ADD, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 32'h0);
        send_item(MODE_ADD, 32'h1);
        send_item(MODE_ADD, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 32'h8000_0000);
        send_item(MODE_ADD, 32'h7FFF_FFFF);
        send_item(MODE_ADD, 32'h0);
        send_item(MODE_ADD, 32'hFFFF_FFFE);
        send_item(MODE_CLEAR, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 32'd3);
        send_item(MODE_ADD, 32'd1);
        send_item(MODE_ADD, 32'd4);
        send_item(MODE_ADD, 32'd1);
        send_item(MODE_ADD, 32'd5);
        send_item(MODE_ADD, 32'd9);
        send_item(MODE_CLEAR, 32'h5555_AAAA);
        send_item(MODE_ADD, 32'hAAAA_5555);

        // Random: mostly samples so both windows fill, occasional clears
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ((i % 60) == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                send_item(MODE_CLEAR, $urandom);
            else
                send_item(MODE_ADD, pick_sample());
        end
        in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples and %0d clears; %0d results checked,",
                 board.samples_seen, board.clears_seen, board.results_seen);
        $display("%0d of them over a full long window.", board.full_long_seen);
        if (board.mismatches == 0)
            $display("tb_windowed_trimmed_mean_core: done, clean");
        else
            $display("tb_windowed_trimmed_mean_core: done, errors");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/wtm_pkg.sv
hw/rtl/wtm_ram.sv
hw/rtl/wtm_div.sv
hw/rtl/wtm_ctrl.sv
hw/rtl/wtm_datapath.sv
hw/rtl/windowed_trimmed_mean_core.sv
tb/tb_windowed_trimmed_mean_core.sv
